[rtl/rlmcs_pkg.sv]
package rlmcs_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_INIT
    } t_state;

    // operation codes carried in tuser of the input stream
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SCAN  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    // byte lanes of one stored pixel, also the order words go out
    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;
    localparam int         CHANNELS = 3;

    localparam int INIT_WORDS = 24;
    localparam int INIT_CNT_W = $clog2(INIT_WORDS);

    localparam logic [3:0] SCAN_BITS  = 4'd8;
    localparam logic [3:0] DC_BITS    = 4'd6;
    localparam logic       BANK_DC    = 1'b0;
    localparam logic       BANK_PIXEL = 1'b1;
    localparam logic [5:0] DC_RESET   = 6'd63;

endpackage

[rtl/rlmcs_ram.sv]
module rlmcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rgb_led_matrix_column_scanner.sv]
// RGB LED matrix column scanner for a shift-register LED driver.
//
// Input stream (s_axis): tuser = op, tdata = column, row, red, green, blue.
//   op write: stores one pixel, no output, ready again at once.
//   op scan:  emits ROWS*3 words of the column (per row blue, green, red).
//   op init:  emits 24 six-bit dot-correction words for bank 0.
//   Unused op codes and writes outside the frame are dropped.
// Output stream (m_axis): one word per transfer; tlast (and the latch flag in
//   tdata) marks the final word, which on a scan also carries the one-hot
//   column enable.
// Config channel: one 6-bit dot-correction register, accepted every cycle.
// Timing: the frame store is a single-port-read RAM with a registered read.
//   A scan first reads row 0, then loads one word per cycle while the output
//   is not stalled, the next row being fetched while red of the current row
//   is loaded. Input ready is low while a scan or init runs and comes back
//   the cycle after the final word is loaded into the output register.
// Stall: the output register holds its word until taken; the sequencer waits.
// Reset: frame store reads as zero (per-pixel valid flags cleared at once,
//   no clearing pass), dot correction returns to 63, output goes empty.
module rgb_led_matrix_column_scanner #(
    parameter int COLUMNS = 8,
    parameter int ROWS    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // column[2:0], row[5:3], red[13:6],
                                          // green[21:14], blue[29:22], zero[31:30]
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // shift_word[7:0], word_bits[11:8],
                                          // latch_after[12], column_enable[20:13],
                                          // zero[23:21]
    output logic [0:0]  o_m_axis_tuser,   // register_bank[0]
    output logic        o_m_axis_tlast,   // last
    // dot-correction register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);

    localparam int PIX = COLUMNS * ROWS;
    localparam int AW  = (PIX > 1) ? $clog2(PIX) : 1;
    localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW  = 8 * rlmcs_pkg::CHANNELS;

    // input fields
    logic [1:0] in_op;
    logic [2:0] in_col;
    logic [2:0] in_row;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    assign in_op    = i_s_axis_tuser;
    assign in_col   = i_s_axis_tdata[2:0];
    assign in_row   = i_s_axis_tdata[5:3];
    assign in_red   = i_s_axis_tdata[13:6];
    assign in_green = i_s_axis_tdata[21:14];
    assign in_blue  = i_s_axis_tdata[29:22];

    // state
    rlmcs_pkg::t_state r_state, n_state;
    logic [2:0]            r_col;
    logic                  r_col_ok;
    logic [RW-1:0]         r_row;
    logic [1:0]            r_ch;
    logic                  r_pix_ok;
    logic [rlmcs_pkg::INIT_CNT_W-1:0] r_init_cnt;
    logic [PIX-1:0]        r_pix_valid;
    logic [5:0]            r_dot_corr;

    // output register
    logic       r_m_valid;
    logic [7:0] r_word;
    logic [3:0] r_bits;
    logic       r_bank;
    logic       r_last;
    logic [7:0] r_en;

    // combinational controls
    logic          in_acc;
    logic          slot_free;
    logic          last_row;
    logic          emit;
    logic          fin;
    logic          ram_re;
    logic          ram_we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [RW-1:0] rd_row;
    logic [PW-1:0] rdata;
    logic [7:0]    rd_byte;
    logic [7:0]    col_en;
    logic [7:0]    word;
    logic [3:0]    bits;
    logic          bank;
    logic [7:0]    en;

    assign o_s_axis_tready = (r_state == rlmcs_pkg::ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free       = !r_m_valid || i_m_axis_tready;
    assign last_row        = (r_row == RW'(ROWS - 1));
    assign o_cfg_ready     = 1'b1;

    // pixel write: all three bytes in one RAM word, address column-major
    assign ram_we = in_acc && (in_op == rlmcs_pkg::OP_WRITE)
                    && (int'(in_col) < COLUMNS) && (int'(in_row) < ROWS);
    assign waddr  = AW'(int'(in_col) * ROWS + int'(in_row));

    // first read uses row 0, later reads prefetch the next row
    assign rd_row = (r_state == rlmcs_pkg::ST_SCAN) ? RW'(r_row + 1'b1) : '0;
    assign raddr  = r_col_ok ? AW'(int'(r_col) * ROWS + int'(rd_row)) : '0;

    assign col_en = r_col_ok ? 8'(8'd1 << r_col) : 8'd0;

    rlmcs_ram #(
        .WIDTH (PW),
        .DEPTH (PIX)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata ({in_red, in_green, in_blue}),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        case (r_ch)
            rlmcs_pkg::CH_BLUE:  rd_byte = rdata[7:0];
            rlmcs_pkg::CH_GREEN: rd_byte = rdata[15:8];
            rlmcs_pkg::CH_RED:   rd_byte = rdata[23:16];
            default:             rd_byte = 8'd0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rlmcs_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_op)
                        rlmcs_pkg::OP_SCAN: n_state = rlmcs_pkg::ST_READ;
                        rlmcs_pkg::OP_INIT: n_state = rlmcs_pkg::ST_INIT;
                        default:            n_state = rlmcs_pkg::ST_IDLE;
                    endcase
                end
            end
            rlmcs_pkg::ST_READ: n_state = rlmcs_pkg::ST_SCAN;
            rlmcs_pkg::ST_SCAN,
            rlmcs_pkg::ST_INIT: begin
                if (emit && fin) begin
                    n_state = rlmcs_pkg::ST_IDLE;
                end
            end
            default: n_state = rlmcs_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ram_re = 1'b0;
        emit   = 1'b0;
        fin    = 1'b0;
        word   = 8'd0;
        bits   = rlmcs_pkg::SCAN_BITS;
        bank   = rlmcs_pkg::BANK_PIXEL;
        en     = 8'd0;
        unique case (r_state)
            rlmcs_pkg::ST_IDLE: ;
            rlmcs_pkg::ST_READ: ram_re = 1'b1;
            rlmcs_pkg::ST_SCAN: begin
                emit   = slot_free;
                fin    = last_row && (r_ch == rlmcs_pkg::CH_RED);
                ram_re = slot_free && (r_ch == rlmcs_pkg::CH_RED) && !last_row;
                word   = r_pix_ok ? rd_byte : 8'd0;
                en     = fin ? col_en : 8'd0;
            end
            rlmcs_pkg::ST_INIT: begin
                emit = slot_free;
                fin  = (r_init_cnt == rlmcs_pkg::INIT_CNT_W'(rlmcs_pkg::INIT_WORDS - 1));
                word = {2'b00, r_dot_corr};
                bits = rlmcs_pkg::DC_BITS;
                bank = rlmcs_pkg::BANK_DC;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlmcs_pkg::ST_IDLE;
            r_m_valid   <= 1'b0;
            r_pix_valid <= '0;
            r_dot_corr  <= rlmcs_pkg::DC_RESET;
            r_row       <= '0;
            r_ch        <= rlmcs_pkg::CH_BLUE;
            r_init_cnt  <= '0;
            r_col_ok    <= 1'b0;
            r_pix_ok    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                r_dot_corr <= i_cfg_data;
            end

            if (ram_we) begin
                r_pix_valid[waddr] <= 1'b1;
            end

            if (in_acc && (in_op == rlmcs_pkg::OP_SCAN)) begin
                r_col_ok <= (int'(in_col) < COLUMNS);
                r_row    <= '0;
            end
            if (in_acc && (in_op == rlmcs_pkg::OP_INIT)) begin
                r_init_cnt <= '0;
            end

            if (r_state == rlmcs_pkg::ST_READ) begin
                r_ch <= rlmcs_pkg::CH_BLUE;
            end

            // unwritten pixel reads as zero
            if (ram_re) begin
                r_pix_ok <= r_col_ok && r_pix_valid[raddr];
            end
            if (ram_re && (r_state == rlmcs_pkg::ST_SCAN)) begin
                r_row <= RW'(r_row + 1'b1);
            end

            if (emit && (r_state == rlmcs_pkg::ST_SCAN)) begin
                r_ch <= (r_ch == rlmcs_pkg::CH_RED) ? rlmcs_pkg::CH_BLUE
                                                    : 2'(r_ch + 2'd1);
            end
            if (emit && (r_state == rlmcs_pkg::ST_INIT)) begin
                r_init_cnt <= rlmcs_pkg::INIT_CNT_W'(r_init_cnt + 1'b1);
            end

            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && (in_op == rlmcs_pkg::OP_SCAN)) begin
            r_col <= in_col;
        end
        if (emit) begin
            r_word <= word;
            r_bits <= bits;
            r_bank <= bank;
            r_last <= fin;
            r_en   <= en;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {3'b000, r_en, r_last, r_bits, r_word};
    assign o_m_axis_tuser  = r_bank;
    assign o_m_axis_tlast  = r_last;

endmodule

[rtl/rlmcs_checker.sv]
module rlmcs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        o_s_axis_tready,
    input  logic [1:0]  i_s_axis_tuser,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [23:0] o_m_axis_tdata,
    input  logic [0:0]  o_m_axis_tuser,
    input  logic        o_m_axis_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("output changed while stalled");

    // column enable and latch only on the final word
    a_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid
        |-> (o_m_axis_tdata[12] == o_m_axis_tlast)
            && (o_m_axis_tlast || (o_m_axis_tdata[20:13] == 8'd0))
            && $onehot0(o_m_axis_tdata[20:13]))
        else $error("bad latch or column enable");

    // dot-correction words are six bits, no column drive
    a_dc_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[0] == rlmcs_pkg::BANK_DC)
        |-> (o_m_axis_tdata[11:8] == rlmcs_pkg::DC_BITS)
            && (o_m_axis_tdata[7:6] == 2'b00) && (o_m_axis_tdata[20:13] == 8'd0))
        else $error("bad dot-correction word");

    a_pix_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[0] == rlmcs_pkg::BANK_PIXEL)
        |-> (o_m_axis_tdata[11:8] == rlmcs_pkg::SCAN_BITS))
        else $error("bad pixel word width");

    // a scan keeps the input closed
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == rlmcs_pkg::OP_SCAN)
        |=> !o_s_axis_tready)
        else $error("input open during scan");

endmodule

bind rgb_led_matrix_column_scanner rlmcs_checker u_rlmcs_checker (.*);

[dv/tb.sv]
`timescale 1ns / 100ps

// Column scanner check: a local frame-store model predicts every drive word
// from the commands as they are taken at the input stream, and the output
// stream is compared against it word by word. Both stream sides idle at
// random, and once the output side holds off long enough to back up the input.
module tb;

    localparam int COLUMNS    = 8;
    localparam int ROWS       = 8;
    localparam int SCAN_WORDS = ROWS * rlmcs_pkg::CHANNELS;
    localparam int SETTLE     = 40;    // idle wait after draining
    localparam int HOLD_LEN   = 300;   // long output hold-off, in cycles

    // op code the block does not use
    localparam logic [1:0] OP_NONE = 2'd3;

    // one input command, fields as they sit in tdata / tuser
    typedef struct packed {
        logic [1:0] op;
        logic [2:0] column;
        logic [2:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_scan_cmd;

    // one word for the LED driver shift chain
    typedef struct packed {
        logic [7:0] word;
        logic [3:0] nbits;
        logic       bank;
        logic       latch;
        logic [7:0] col_en;
        logic       fin;
    } t_drive_word;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_valid = 1'b0;
    t_scan_cmd   s_cmd   = '0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_data;
    logic [0:0]  m_user;
    logic        m_last;
    logic        cfg_valid = 1'b0;
    logic [5:0]  cfg_data  = '0;
    logic        cfg_ready;

    // model state
    logic [7:0]  pix_mem [COLUMNS][ROWS][rlmcs_pkg::CHANNELS];
    logic [5:0]  dc_model = rlmcs_pkg::DC_RESET;

    t_scan_cmd   cmd_q [$];
    t_drive_word word_q [$];
    int          cmds_issued   = 0;
    int          cmds_accepted = 0;
    int          errors        = 0;
    int          send_gap      = 0;
    int          recv_gap      = 0;
    int          hold_left     = 0;
    bit          hold_req      = 1'b0;
    bit          hold_done     = 1'b0;
    bit          quiet         = 1'b0;   // no idling on either side

    rgb_led_matrix_column_scanner #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  ({2'b00, s_cmd.blue, s_cmd.green, s_cmd.red,
                           s_cmd.row, s_cmd.column}),
        .i_s_axis_tuser  (s_cmd.op),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Frame-store model: applies one taken command and queues the words it
    // should produce.
    task automatic apply_command(input t_scan_cmd c);
        t_drive_word w;
        logic        col_ok;
        logic [7:0]  en;
        case (c.op)
            rlmcs_pkg::OP_WRITE: begin
                // writes outside the frame are dropped
                if (c.column < COLUMNS && c.row < ROWS) begin
                    pix_mem[c.column][c.row][rlmcs_pkg::CH_BLUE]  = c.blue;
                    pix_mem[c.column][c.row][rlmcs_pkg::CH_GREEN] = c.green;
                    pix_mem[c.column][c.row][rlmcs_pkg::CH_RED]   = c.red;
                end
            end
            rlmcs_pkg::OP_SCAN: begin
                col_ok = c.column < COLUMNS;
                en = (col_ok && c.column < 8) ? 8'd1 << c.column : 8'd0;
                for (int k = 0; k < SCAN_WORDS; k++) begin
                    w.word   = col_ok ? pix_mem[c.column][k / rlmcs_pkg::CHANNELS]
                                               [k % rlmcs_pkg::CHANNELS]
                                      : 8'd0;
                    w.nbits  = rlmcs_pkg::SCAN_BITS;
                    w.bank   = rlmcs_pkg::BANK_PIXEL;
                    w.fin    = (k == SCAN_WORDS - 1);
                    w.latch  = w.fin;
                    w.col_en = w.fin ? en : 8'd0;
                    word_q.push_back(w);
                end
            end
            rlmcs_pkg::OP_INIT: begin
                // same correction word for every channel, frame untouched
                for (int k = 0; k < rlmcs_pkg::INIT_WORDS; k++) begin
                    w.word   = {2'b00, dc_model};
                    w.nbits  = rlmcs_pkg::DC_BITS;
                    w.bank   = rlmcs_pkg::BANK_DC;
                    w.fin    = (k == rlmcs_pkg::INIT_WORDS - 1);
                    w.latch  = w.fin;
                    w.col_en = 8'd0;
                    word_q.push_back(w);
                end
            end
            default: ;   // unused op: ignored
        endcase
    endtask

    initial begin
        for (int x = 0; x < COLUMNS; x++)
            for (int y = 0; y < ROWS; y++)
                for (int ch = 0; ch < rlmcs_pkg::CHANNELS; ch++)
                    pix_mem[x][y][ch] = 8'd0;
    end

    // Input driver: presents queued commands, with random idle bursts.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_command(s_cmd);
                cmds_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (cmd_q.size() != 0 && !quiet && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(1, 18) - 1;
                    s_valid <= 1'b0;
                end else if (cmd_q.size() != 0) begin
                    s_cmd   <= cmd_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off; the input keeps offering meanwhile.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            hold_left = 0;
        end else if (hold_req && !hold_done) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
        end else if (hold_left != 0) begin
            hold_left--;
        end
    end

    // Output monitor: checks each transfer against the oldest predicted word.
    always @(posedge i_clk) begin
        t_drive_word got;
        t_drive_word exp_w;
        if (!rst_n) begin
            m_ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.word   = m_data[7:0];
                got.nbits  = m_data[11:8];
                got.latch  = m_data[12];
                got.col_en = m_data[20:13];
                got.bank   = m_user[0];
                got.fin    = m_last;
                if (word_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected word %h", $realtime, got);
                end else begin
                    exp_w = word_q.pop_front();
                    if (got.word !== exp_w.word || got.nbits !== exp_w.nbits ||
                        got.bank !== exp_w.bank || got.latch !== exp_w.latch ||
                        got.col_en !== exp_w.col_en || got.fin !== exp_w.fin) begin
                        errors++;
                        // word bits bank latch en last
                        if (errors <= 10)
                            $display("%0t: mismatch exp %h %0d %b %b %h %b act %h %0d %b %b %h %b",
                                     $realtime, exp_w.word, exp_w.nbits, exp_w.bank,
                                     exp_w.latch, exp_w.col_en, exp_w.fin, got.word,
                                     got.nbits, got.bank, got.latch, got.col_en, got.fin);
                    end
                end
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_cmd(input logic [1:0] op, input logic [2:0] x, input logic [2:0] y,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_scan_cmd c;
        c = '{op: op, column: x, row: y, red: r, green: g, blue: b};
        cmd_q.push_back(c);
        cmds_issued++;
    endtask

    // one command on column x, other fields random
    task automatic push_op(input logic [1:0] op, input logic [2:0] x);
        push_cmd(op, x, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Random traffic: mostly single writes, plus writes followed by a scan of
    // the same column, inits, unused ops and stray scans. Unused ops don't count.
    task automatic push_random(input int n);
        int cnt;
        int pick;
        logic [2:0] x;
        cnt = 0;
        while (cnt < n) begin
            pick = $urandom_range(0, 99);
            x = 3'($urandom_range(0, 7));
            if (pick < 50) begin
                push_op(rlmcs_pkg::OP_WRITE, x);
                cnt++;
            end else if (pick < 70) begin
                // fill part of a column, then scan it
                for (int k = $urandom_range(1, 4); k > 0; k--) begin
                    push_op(rlmcs_pkg::OP_WRITE, x);
                    cnt++;
                end
                push_op(rlmcs_pkg::OP_SCAN, x);
                cnt++;
            end else if (pick < 82) begin
                push_op(rlmcs_pkg::OP_SCAN, x);
                cnt++;
            end else if (pick < 90) begin
                push_op(rlmcs_pkg::OP_INIT, x);
                cnt++;
            end else begin
                push_op(OP_NONE, x);
            end
        end
    endtask

    // all commands taken and all words seen, then let the sequencer settle
    task automatic wait_drained();
        while (cmds_accepted != cmds_issued || word_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_dot_corr(input logic [5:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
        dc_model = val;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: empty frame, reset correction, unused op, corner pixels
        push_cmd(rlmcs_pkg::OP_SCAN,  3'd3, 3'd0, 8'h00, 8'h00, 8'h00);
        push_cmd(rlmcs_pkg::OP_INIT,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
        push_cmd(OP_NONE,             3'd7, 3'd7, 8'hff, 8'hff, 8'hff);
        push_cmd(rlmcs_pkg::OP_WRITE, 3'd0, 3'd0, 8'hff, 8'h00, 8'hff);
        push_cmd(rlmcs_pkg::OP_WRITE, 3'd0, 3'd7, 8'ha5, 8'h5a, 8'h3c);
        push_cmd(rlmcs_pkg::OP_WRITE, 3'd7, 3'd7, 8'hff, 8'hff, 8'hff);
        push_cmd(rlmcs_pkg::OP_WRITE, 3'd7, 3'd0, 8'h00, 8'h00, 8'h00);
        push_cmd(rlmcs_pkg::OP_WRITE, 3'd7, 3'd3, 8'h01, 8'h80, 8'h7f);
        push_cmd(rlmcs_pkg::OP_WRITE, 3'd3, 3'd4, 8'h12, 8'h34, 8'h56);
        push_cmd(rlmcs_pkg::OP_SCAN,  3'd0, 3'd5, 8'hff, 8'hff, 8'hff);
        push_cmd(rlmcs_pkg::OP_SCAN,  3'd7, 3'd0, 8'h00, 8'h00, 8'h00);
        push_cmd(rlmcs_pkg::OP_SCAN,  3'd3, 3'd0, 8'h00, 8'h00, 8'h00);
        // unused op carrying a write's fields must not touch the frame
        push_cmd(OP_NONE,             3'd0, 3'd0, 8'h11, 8'h22, 8'h33);
        push_cmd(rlmcs_pkg::OP_SCAN,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
        push_cmd(rlmcs_pkg::OP_WRITE, 3'd0, 3'd0, 8'h00, 8'hff, 8'h00);
        push_cmd(rlmcs_pkg::OP_SCAN,  3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
        push_cmd(rlmcs_pkg::OP_INIT,  3'd7, 3'd7, 8'hff, 8'hff, 8'hff);
        push_cmd(rlmcs_pkg::OP_SCAN,  3'd7, 3'd7, 8'hff, 8'hff, 8'hff);
        wait_drained();

        write_dot_corr(6'd0);
        push_cmd(rlmcs_pkg::OP_INIT, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00);
        push_random(80);
        wait_drained();

        // mid-range correction; output backs up for a while
        write_dot_corr(6'($urandom_range(1, 62)));
        push_random(40);
        hold_req = 1'b1;
        push_random(40);
        wait_drained();

        // last part: no idling on either side
        write_dot_corr(6'd63);
        quiet = 1'b1;
        push_random(80);
        wait_drained();

        if (word_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
